@@ hw/rtl/lcfs_pkg.sv @@
`timescale 1ns / 1ps

package lcfs_pkg;

    // defaults for the top-level parameters
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_ID_BITS     = 16;

    // fixed field widths
    localparam int SVC_W = 32;
    localparam int NOW_W = 48;
    localparam int FIN_W = 49;

    // command codes
    localparam logic CMD_ARRIVE   = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // stack operation for one event
    typedef struct packed {
        logic push;
        logic remove;
    } t_stack_cmd;

endpackage

@@ hw/rtl/lcfs_in_if.sv @@
`timescale 1ns / 1ps

interface lcfs_in_if import lcfs_pkg::*; #(
    parameter int ID_BITS = DEF_ID_BITS
) ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [ID_BITS-1:0] job_id;
    logic [SVC_W-1:0]   service_time;
    logic [NOW_W-1:0]   now_time;

    modport source (
        output valid, command, job_id, service_time, now_time,
        input  ready
    );

    modport sink (
        input  valid, command, job_id, service_time, now_time,
        output ready
    );
endinterface

@@ hw/rtl/lcfs_out_if.sv @@
`timescale 1ns / 1ps

interface lcfs_out_if import lcfs_pkg::*; #(
    parameter int ID_BITS = DEF_ID_BITS
) ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic               done_valid;
    logic [ID_BITS-1:0] done_job;
    logic               start_valid;
    logic [ID_BITS-1:0] started_job;
    logic [FIN_W-1:0]   finish_time;

    modport source (
        output valid, status, done_valid, done_job, start_valid, started_job,
               finish_time,
        input  ready
    );

    modport sink (
        input  valid, status, done_valid, done_job, start_valid, started_job,
               finish_time,
        output ready
    );
endinterface

@@ hw/rtl/lcfs_stack.sv @@
`timescale 1ns / 1ps

// register stack, newest entry at index 0
module lcfs_stack import lcfs_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    localparam int POS_W      = $clog2(STACK_DEPTH)
) (
    input  logic               i_clk,
    input  t_stack_cmd         i_cmd,
    input  logic [POS_W-1:0]   i_rm_pos,
    input  logic [ID_BITS-1:0] i_push_id,
    input  logic [SVC_W-1:0]   i_push_time,
    output logic [ID_BITS-1:0] o_top_id,
    output logic [SVC_W-1:0]   o_top_time,
    output logic [ID_BITS-1:0] o_next_id,
    output logic [SVC_W-1:0]   o_next_time
);

    logic [ID_BITS-1:0] r_ids   [STACK_DEPTH];
    logic [SVC_W-1:0]   r_times [STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            // push shifts every entry one place deeper
            r_ids[0]   <= i_push_id;
            r_times[0] <= i_push_time;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                r_ids[i]   <= r_ids[i-1];
                r_times[i] <= r_times[i-1];
            end
        end else if (i_cmd.remove) begin
            // entries deeper than the removed one close the gap
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                if (POS_W'(i) >= i_rm_pos) begin
                    r_ids[i]   <= r_ids[i+1];
                    r_times[i] <= r_times[i+1];
                end
            end
        end
    end

    assign o_top_id    = r_ids[0];
    assign o_top_time  = r_times[0];
    assign o_next_id   = r_ids[1];
    assign o_next_time = r_times[1];

endmodule

@@ hw/rtl/lcfs_nonpreemptive_job_scheduler.sv @@
`timescale 1ns / 1ps

// channel | dir | modport        | transaction
// i_in    | in  | lcfs_in_if     | command, job_id, service_time, now_time
// o_out   | out | lcfs_out_if    | status, done/start flags, job ids, finish_time
//
// one transaction per cycle sustained while o_out.ready is high: input register,
// one pass of stack logic and a 49-bit add, then the result register
// an accepted event is held in the input register, then moves into the result register
// i_rst_n (synchronous, active low) empties the stack; stack contents are
// not cleared, only entries below the count are ever read
// a stalled result holds the result register and, once the input register
// is also full, drops i_in.ready

module lcfs_nonpreemptive_job_scheduler import lcfs_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcfs_in_if.sink    i_in,
    lcfs_out_if.source o_out
);

    localparam int POS_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    // input register
    logic               r_in_valid;
    logic               r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic [SVC_W-1:0]   r_svc;
    logic [NOW_W-1:0]   r_now;

    // scheduler state
    logic [CNT_W-1:0]   r_count;   // number of stacked jobs
    logic [POS_W-1:0]   r_pos;     // depth of running job, 0 = newest
    logic [ID_BITS-1:0] r_run_id;  // id of running job

    // result register
    logic               r_out_valid;
    t_status            r_status;
    logic               r_done_valid;
    logic [ID_BITS-1:0] r_done_job;
    logic               r_start_valid;
    logic [ID_BITS-1:0] r_started_job;
    logic [FIN_W-1:0]   r_finish;

    // next values
    logic [CNT_W-1:0]   n_count;
    logic [POS_W-1:0]   n_pos;
    logic [ID_BITS-1:0] n_run_id;
    t_status            n_status;
    logic               n_done_valid;
    logic [ID_BITS-1:0] n_done_job;
    logic               n_start_valid;
    logic [ID_BITS-1:0] n_started_job;
    logic [FIN_W-1:0]   n_finish;

    t_stack_cmd         stk_cmd;
    logic [ID_BITS-1:0] top_id, next_id, new_top_id;
    logic [SVC_W-1:0]   top_time, next_time, new_top_time;
    logic               in_fire;
    logic               go;

    // event in the input register moves on when the result slot frees up
    assign go       = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_fire  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || go;

    lcfs_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_stack (
        .i_clk       (i_clk),
        .i_cmd       (stk_cmd),
        .i_rm_pos    (r_pos),
        .i_push_id   (r_id),
        .i_push_time (r_svc),
        .o_top_id    (top_id),
        .o_top_time  (top_time),
        .o_next_id   (next_id),
        .o_next_time (next_time)
    );

    // after removing the running job: if it was the newest, the one below
    // becomes the newest, otherwise the newest stays in place
    assign new_top_id   = (r_pos == '0) ? next_id   : top_id;
    assign new_top_time = (r_pos == '0) ? next_time : top_time;

    always_comb begin
        stk_cmd       = '0;
        n_count       = r_count;
        n_pos         = r_pos;
        n_run_id      = r_run_id;
        n_status      = ST_OK;
        n_done_valid  = 1'b0;
        n_done_job    = '0;
        n_start_valid = 1'b0;
        n_started_job = '0;
        n_finish      = '0;

        if (r_cmd == CMD_ARRIVE) begin
            if (r_count == CNT_W'(STACK_DEPTH)) begin
                // full stack drops the arrival
                n_status = ST_FULL;
            end else begin
                stk_cmd.push = go;
                n_count      = r_count + CNT_W'(1);
                if (r_count == '0) begin
                    // idle scheduler starts the job at once
                    n_pos         = '0;
                    n_run_id      = r_id;
                    n_start_valid = 1'b1;
                    n_started_job = r_id;
                    n_finish      = FIN_W'(r_now) + FIN_W'(r_svc);
                end else begin
                    // no preemption, running job sinks one place
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                stk_cmd.remove = go;
                n_count        = r_count - CNT_W'(1);
                n_done_valid   = 1'b1;
                n_done_job     = r_run_id;
                n_pos          = '0;
                if (r_count != CNT_W'(1)) begin
                    // newest remaining job starts
                    n_run_id      = new_top_id;
                    n_start_valid = 1'b1;
                    n_started_job = new_top_id;
                    n_finish      = FIN_W'(r_now) + FIN_W'(new_top_time);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_pos       <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end

            if (go) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_pos       <= n_pos;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in.command;
            r_id  <= i_in.job_id;
            r_svc <= i_in.service_time;
            r_now <= i_in.now_time;
        end
        if (go) begin
            r_run_id      <= n_run_id;
            r_status      <= n_status;
            r_done_valid  <= n_done_valid;
            r_done_job    <= n_done_job;
            r_start_valid <= n_start_valid;
            r_started_job <= n_started_job;
            r_finish      <= n_finish;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.done_valid  = r_done_valid;
    assign o_out.done_job    = r_done_job;
    assign o_out.start_valid = r_start_valid;
    assign o_out.started_job = r_started_job;
    assign o_out.finish_time = r_finish;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lcfs_pkg::*;

    localparam int DEPTH          = DEF_STACK_DEPTH;
    localparam int IDW            = DEF_ID_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 246;

    // one scheduler response, field for field as on o_out
    typedef struct packed {
        t_status            status;
        logic               done_valid;
        logic [IDW-1:0]     done_job;
        logic               start_valid;
        logic [IDW-1:0]     started_job;
        logic [FIN_W-1:0]   finish_time;
    } t_sched_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcfs_in_if  #(.ID_BITS(IDW)) in_bus ();
    lcfs_out_if #(.ID_BITS(IDW)) out_bus ();

    lcfs_nonpreemptive_job_scheduler #(
        .STACK_DEPTH (DEPTH),
        .ID_BITS     (IDW)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the job stack
    logic [IDW-1:0]   shadow_ids [DEPTH];
    logic [SVC_W-1:0] shadow_svc [DEPTH];
    int               shadow_depth = 0;
    int               shadow_run   = 0;

    // responses still owed by the scheduler, oldest first
    t_sched_result    owed_results[$];

    // sender and receiver pacing
    bit               sender_idles  = 1'b1;
    bit               receiver_stalls = 1'b1;
    int               burst_left    = 0;

    // bookkeeping
    int               mismatches      = 0;
    int               checked         = 0;
    int               n_arrivals      = 0;
    int               n_dropped       = 0;
    int               n_completions   = 0;
    int               n_empty_done    = 0;
    int               deepest         = 0;
    int               quiet_cycles    = 0;

    // next scheduler response for one event, updating the shadow stack
    function automatic t_sched_result predict_schedule(
        logic cmd, logic [IDW-1:0] id, logic [SVC_W-1:0] svc, logic [NOW_W-1:0] now
    );
        t_sched_result r;
        int slot;
        r        = '0;
        r.status = ST_OK;
        if (cmd == CMD_ARRIVE) begin
            if (shadow_depth >= DEPTH) begin
                // full stack: job dropped, nothing moves
                r.status = ST_FULL;
                n_dropped++;
            end else begin
                shadow_ids[shadow_depth] = id;
                shadow_svc[shadow_depth] = svc;
                shadow_depth++;
                n_arrivals++;
                // only an arrival onto an empty stack starts a job
                if (shadow_depth == 1) begin
                    shadow_run    = 0;
                    r.start_valid = 1'b1;
                    r.started_job = id;
                    r.finish_time = {1'b0, now} + FIN_W'(svc);
                end
            end
        end else if (shadow_depth == 0) begin
            r.status = ST_EMPTY;
            n_empty_done++;
        end else begin
            slot = shadow_run;
            if (slot >= shadow_depth) begin
                slot = shadow_depth - 1;
            end
            r.done_valid = 1'b1;
            r.done_job   = shadow_ids[slot];
            // newer entries above the running job close the gap
            for (int i = slot; i + 1 < shadow_depth; i++) begin
                shadow_ids[i] = shadow_ids[i + 1];
                shadow_svc[i] = shadow_svc[i + 1];
            end
            shadow_depth--;
            n_completions++;
            if (shadow_depth > 0) begin
                // newest waiting job starts with its full service time
                shadow_run    = shadow_depth - 1;
                r.start_valid = 1'b1;
                r.started_job = shadow_ids[shadow_run];
                r.finish_time = {1'b0, now} + FIN_W'(shadow_svc[shadow_run]);
            end else begin
                shadow_run = 0;
            end
        end
        if (shadow_depth > deepest) begin
            deepest = shadow_depth;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [FIN_W-1:0] want,
                                        logic [FIN_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // one event transaction on i_in; called right after a rising edge
    task automatic send_event(logic cmd, logic [IDW-1:0] id, logic [SVC_W-1:0] svc,
                              logic [NOW_W-1:0] now);
        in_bus.valid        <= 1'b1;
        in_bus.command      <= cmd;
        in_bus.job_id       <= id;
        in_bus.service_time <= svc;
        in_bus.now_time     <= now;
        do @(posedge i_clk); while (!in_bus.ready);
        owed_results.push_back(predict_schedule(cmd, id, svc, now));
        // end of a burst: drop valid for a random gap
        if (sender_idles) begin
            if (burst_left == 0) begin
                in_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // random event; arrive_pct sets how often it is an arrival
    task automatic send_random(int arrive_pct);
        logic [SVC_W-1:0] svc;
        logic [NOW_W-1:0] now;
        case ($urandom_range(0, 7))
            0:       svc = '0;
            1:       svc = '1;
            default: svc = SVC_W'($urandom);
        endcase
        case ($urandom_range(0, 15))
            0:       now = '0;
            1:       now = '1;
            default: now = {16'($urandom), 32'($urandom)};
        endcase
        send_event(($urandom_range(1, 100) <= arrive_pct) ? CMD_ARRIVE : CMD_COMPLETE,
                   IDW'($urandom), svc, now);
    endtask

    task automatic test_completion_on_empty();
        send_event(CMD_COMPLETE, IDW'($urandom), SVC_W'($urandom), {16'($urandom), 32'($urandom)});
    endtask

    // largest time sum carries into the top finish bit, then all-zero fields
    task automatic test_field_extremes();
        send_event(CMD_ARRIVE, '1, '1, '1);
        send_event(CMD_ARRIVE, '0, '0, '0);
        send_event(CMD_COMPLETE, '0, '0, '1);
    endtask

    // the running job sits below a newer arrival when it completes
    task automatic test_running_below_newer();
        send_event(CMD_ARRIVE, 16'h1111, 32'd100, 48'd10);
        send_event(CMD_ARRIVE, 16'h2222, 32'd200, 48'd11);
        send_event(CMD_COMPLETE, '0, '0, 48'd20);
        send_event(CMD_ARRIVE, 16'h3333, 32'd300, 48'd21);
        send_event(CMD_COMPLETE, '0, '0, 48'd30);
    endtask

    // fill the stack, then one more arrival is dropped
    task automatic test_arrival_into_full();
        while (shadow_depth < DEPTH) begin
            send_event(CMD_ARRIVE, IDW'($urandom), SVC_W'($urandom), {16'($urandom), 32'($urandom)});
        end
        send_event(CMD_ARRIVE, IDW'($urandom), SVC_W'($urandom), {16'($urandom), 32'($urandom)});
    endtask

    // phases of different arrival mix so the stack swings between empty and full
    task automatic test_random_traffic();
        int mix [RANDOM_PHASES] = '{50, 90, 15, 60, 97, 5, 50};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // first phase runs with no idling on either side
            sender_idles    = (p != 0);
            receiver_stalls = (p != 0) && (p != 5);
            repeat (PHASE_ITEMS) send_random(mix[p]);
        end
    endtask

    // receiver: rotating stall pattern, refreshed after each pass through it
    initial begin
        logic [15:0] pattern;
        int          pos;
        pattern = 16'hFFFF;
        pos     = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_bus.ready <= receiver_stalls ? pattern[pos] : 1'b1;
            pos++;
            if (pos == 16) begin
                pos     = 0;
                // never an all-zero pattern, sometimes a stall-free one
                pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
            end
        end
    end

    // result checker: each accepted transaction against the oldest owed response
    always @(posedge i_clk) begin : check_results
        t_sched_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (owed_results.size() == 0) begin
                $error("result transaction with no owed response");
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                check_field("status", FIN_W'(want.status), FIN_W'(out_bus.status));
                check_field("done_valid", FIN_W'(want.done_valid), FIN_W'(out_bus.done_valid));
                check_field("done_job", FIN_W'(want.done_job), FIN_W'(out_bus.done_job));
                check_field("start_valid", FIN_W'(want.start_valid),
                            FIN_W'(out_bus.start_valid));
                check_field("started_job", FIN_W'(want.started_job),
                            FIN_W'(out_bus.started_job));
                check_field("finish_time", want.finish_time, out_bus.finish_time);
                checked++;
            end
        end
    end

    // cycles since the last transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        // known values from time zero, with reset held low at the start
        i_rst_n             <= 1'b0;
        in_bus.valid        <= 1'b0;
        in_bus.command      <= CMD_ARRIVE;
        in_bus.job_id       <= '0;
        in_bus.service_time <= '0;
        in_bus.now_time     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_completion_on_empty();
        test_field_extremes();
        test_running_below_newer();
        test_arrival_into_full();
        test_random_traffic();

        in_bus.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d arrivals, %0d dropped on a full stack, %0d completions, %0d on an empty stack",
                 n_arrivals, n_dropped, n_completions, n_empty_done);
        $display("%0d responses checked, deepest stack %0d of %0d", checked, deepest, DEPTH);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
